// ===== rtl/core/spq_pkg.sv =====
// Shared definitions for the sorted priority queue: sizes, codes and
// the stored entry type. Depends on nothing; used by every file in rtl/core.
package spq_pkg;

   localparam int DEPTH  = 16;
   localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int KEY_W  = 32;
   localparam int DATA_W = 32;
   localparam int OCC_W  = 5;
   localparam int STAT_W = 2;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_DELETE = 1'b1;

   localparam logic [STAT_W-1:0] STATUS_DONE  = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic signed [KEY_W-1:0] key;
      logic [DATA_W-1:0]       data;
   } entry_type;

   // One access slot of the entry store per cycle: an optional write and a read.
   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      entry_type        wr_entry;
      logic [IDX_W-1:0] rd_addr;
   } store_req_type;

   typedef enum logic [5:0] {
      ST_IDLE    = 6'b000001,
      ST_INS_RD  = 6'b000010,
      ST_INS_CMP = 6'b000100,
      ST_INS_PUT = 6'b001000,
      ST_DEL_RD  = 6'b010000,
      ST_DEL_MV  = 6'b100000
   } state_type;

endpackage

// ===== rtl/core/spq_store.sv =====
// Entry store of the sorted priority queue: one write and one registered
// read per cycle. Depends on spq_pkg for the entry and request types.
module spq_store (
   input  logic                   clock,
   input  spq_pkg::store_req_type req,
   output spq_pkg::entry_type     rd_entry
);

   spq_pkg::entry_type mem [spq_pkg::DEPTH];
   spq_pkg::entry_type rd_entry_ff;

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.wr_addr] <= req.wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      rd_entry_ff <= mem[req.rd_addr];
   end

   assign rd_entry = rd_entry_ff;

endmodule

// ===== rtl/core/sorted_priority_queue.sv =====
// Sorted min-priority queue: sequencer and one shared key comparator over the entry store
// in spq_store; sizes and codes come from spq_pkg.
// A refused insert or a delete on an empty queue answers in the cycle after start.
// An insert reads and compares each entry from the tail until it stops at a smaller key,
// or writes the new entry at address 0 once it has moved them all; a delete reads and
// moves each entry in turn. busy stays high throughout; synchronous reset empties it.
module sorted_priority_queue (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_operation,
   input  logic signed [spq_pkg::KEY_W-1:0] req_key,
   input  logic [spq_pkg::DATA_W-1:0]       req_data,
   output logic                             rsp_strobe,
   output logic [spq_pkg::STAT_W-1:0]       rsp_status,
   output logic signed [spq_pkg::KEY_W-1:0] rsp_out_key,
   output logic [spq_pkg::DATA_W-1:0]       rsp_out_data,
   output logic [spq_pkg::OCC_W-1:0]        rsp_occupancy
);

   localparam int IDX_W = spq_pkg::IDX_W;
   localparam int CNT_W = spq_pkg::CNT_W;

   spq_pkg::state_type state_ff, state_in;

   // Entries are kept in ascending key order at addresses 0 .. fill_ff-1.
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [IDX_W-1:0] idx_ff, idx_in;

   // The accepted word is held for the whole operation.
   spq_pkg::entry_type               new_ff, new_in;

   logic                             strobe_ff, strobe_in;
   logic [spq_pkg::STAT_W-1:0]       status_ff, status_in;
   logic signed [spq_pkg::KEY_W-1:0] out_key_ff, out_key_in;
   logic [spq_pkg::DATA_W-1:0]       out_data_ff, out_data_in;

   spq_pkg::store_req_type store_req;
   spq_pkg::entry_type     rd_entry;

   logic [CNT_W-1:0] fill_m1;
   logic [IDX_W-1:0] idx_p1;
   logic [IDX_W-1:0] idx_m1;
   logic             key_ge;
   logic             idx_last;
   logic             accept;
   logic [CNT_W+spq_pkg::OCC_W-1:0] occ_wide;

   spq_store u_store (
      .clock    (clock),
      .req      (store_req),
      .rd_entry (rd_entry)
   );

   assign accept   = start && (state_ff == spq_pkg::ST_IDLE);
   assign fill_m1  = fill_ff - CNT_W'(1);
   assign idx_p1   = idx_ff + IDX_W'(1);
   assign idx_m1   = idx_ff - IDX_W'(1);
   // The one shared comparator: stored key against the new key, signed.
   assign key_ge   = (rd_entry.key >= new_ff.key);
   assign idx_last = (CNT_W'(idx_ff) == fill_m1);

   always_comb begin
      state_in    = state_ff;
      fill_in     = fill_ff;
      idx_in      = idx_ff;
      new_in      = new_ff;
      strobe_in   = 1'b0;
      status_in   = status_ff;
      out_key_in  = out_key_ff;
      out_data_in = out_data_ff;

      store_req          = '0;
      store_req.rd_addr  = idx_ff;
      store_req.wr_entry = new_ff;

      case (state_ff)
         spq_pkg::ST_IDLE: begin
            if (accept) begin
               new_in.key  = req_key;
               new_in.data = req_data;
               out_key_in  = '0;
               out_data_in = '0;
               if (req_operation == spq_pkg::OP_INSERT) begin
                  if (fill_ff == CNT_W'(spq_pkg::DEPTH)) begin
                     strobe_in = 1'b1;
                     status_in = spq_pkg::STATUS_FULL;
                  end else if (fill_ff == '0) begin
                     state_in = spq_pkg::ST_INS_PUT;
                  end else begin
                     idx_in   = fill_m1[IDX_W-1:0];
                     state_in = spq_pkg::ST_INS_RD;
                  end
               end else begin
                  if (fill_ff == '0) begin
                     strobe_in = 1'b1;
                     status_in = spq_pkg::STATUS_EMPTY;
                  end else begin
                     idx_in   = '0;
                     state_in = spq_pkg::ST_DEL_RD;
                  end
               end
            end
         end

         // Insert walks from the tail toward the head, moving every entry whose key
         // is greater than or equal to the new key up by one address.
         spq_pkg::ST_INS_RD: begin
            state_in = spq_pkg::ST_INS_CMP;
         end

         spq_pkg::ST_INS_CMP: begin
            store_req.wr_en   = 1'b1;
            store_req.wr_addr = idx_p1;
            if (key_ge) begin
               store_req.wr_entry = rd_entry;
               if (idx_ff == '0) begin
                  state_in = spq_pkg::ST_INS_PUT;
               end else begin
                  idx_in   = idx_m1;
                  state_in = spq_pkg::ST_INS_RD;
               end
            end else begin
               strobe_in = 1'b1;
               status_in = spq_pkg::STATUS_DONE;
               fill_in   = fill_ff + CNT_W'(1);
               state_in  = spq_pkg::ST_IDLE;
            end
         end

         spq_pkg::ST_INS_PUT: begin
            store_req.wr_en   = 1'b1;
            store_req.wr_addr = '0;
            strobe_in         = 1'b1;
            status_in         = spq_pkg::STATUS_DONE;
            fill_in           = fill_ff + CNT_W'(1);
            state_in          = spq_pkg::ST_IDLE;
         end

         // Delete reads the head first, then moves each later entry down by one.
         spq_pkg::ST_DEL_RD: begin
            state_in = spq_pkg::ST_DEL_MV;
         end

         spq_pkg::ST_DEL_MV: begin
            if (idx_ff == '0) begin
               out_key_in  = rd_entry.key;
               out_data_in = rd_entry.data;
            end else begin
               store_req.wr_en    = 1'b1;
               store_req.wr_addr  = idx_m1;
               store_req.wr_entry = rd_entry;
            end
            if (idx_last) begin
               strobe_in = 1'b1;
               status_in = spq_pkg::STATUS_DONE;
               fill_in   = fill_m1;
               state_in  = spq_pkg::ST_IDLE;
            end else begin
               idx_in   = idx_p1;
               state_in = spq_pkg::ST_DEL_RD;
            end
         end

         default: begin
            state_in = spq_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= spq_pkg::ST_IDLE;
         fill_ff   <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         fill_ff   <= fill_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      new_ff      <= new_in;
      status_ff   <= status_in;
      out_key_ff  <= out_key_in;
      out_data_ff <= out_data_in;
   end

   // The count is updated at the same edge that raises the strobe, so it is
   // the occupancy after the operation; it wraps if it outgrows the field.
   assign occ_wide = {{spq_pkg::OCC_W{1'b0}}, fill_ff};

   assign busy          = (state_ff != spq_pkg::ST_IDLE);
   assign rsp_strobe    = strobe_ff;
   assign rsp_status    = status_ff;
   assign rsp_out_key   = out_key_ff;
   assign rsp_out_data  = out_data_ff;
   assign rsp_occupancy = occ_wide[spq_pkg::OCC_W-1:0];

   // An accepted word either starts a multi-cycle operation or answers at once.
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      accept |=> (busy || rsp_strobe))
      else $error("accepted word neither started nor answered");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobe while still busy");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(spq_pkg::DEPTH))
      else $error("fill level beyond depth");

   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status != spq_pkg::STATUS_DONE)
         |-> (rsp_out_key == '0 && rsp_out_data == '0))
      else $error("refused operation returned nonzero payload");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == spq_pkg::STATUS_FULL) |-> fill_ff == CNT_W'(spq_pkg::DEPTH))
      else $error("full status with room left");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == spq_pkg::STATUS_EMPTY) |-> fill_ff == '0)
      else $error("empty status with entries held");

endmodule
